@@ rtl/yiq2ycc_pkg.sv @@
// Shared types and constants for the YIQ to YCbCr converter.
// No dependencies; imported by the divider, the top level and the checker.
package yiq2ycc_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLACK_LEVEL = 2'd0,
        REG_WHITE_LEVEL = 2'd1,
        REG_WHITE_PT_75 = 2'd2,
        REG_CHROMA_GAIN = 2'd3
    } cfg_reg_t;

    localparam logic [15:0] BLACK_LEVEL_RST = 16'd16384;
    localparam logic [15:0] WHITE_LEVEL_RST = 16'd54016;
    localparam logic        WHITE_PT_75_RST = 1'b0;
    localparam logic [15:0] CHROMA_GAIN_RST = 16'd4096;

    // Black-to-white output span (219 * 257); the divider numerator carries an
    // extra factor of 4 so the 1.25 gain of the 75 percent mode stays integral.
    localparam int unsigned LUMA_SPAN_CODE = 219 * 257;
    localparam logic [18:0] LUMA_K_FULL    = 19'(LUMA_SPAN_CODE * 4);
    localparam logic [18:0] LUMA_K_WP75    = 19'(LUMA_SPAN_CODE * 5);

    // Rotation by 33 degrees folded with the Cb/Cr factors, 8 fractional bits
    localparam int K_W = 25;
    localparam logic signed [K_W-1:0] K_CB_I = 25'sd9168742;
    localparam logic signed [K_W-1:0] K_CB_Q = 25'sd14118625;
    localparam logic signed [K_W-1:0] K_CR_I = 25'sd10009942;
    localparam logic signed [K_W-1:0] K_CR_Q = 25'sd6500532;

    localparam logic [15:0] LUMA_OFFSET   = 16'(16 * 256);
    localparam logic [15:0] CHROMA_OFFSET = 16'(128 * 256);
    localparam logic [15:0] OUT_MIN       = 16'(256);
    localparam logic [15:0] OUT_MAX       = 16'(65216);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/yiq2ycc_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, used for the scale factors.
// Depends on yiq2ycc_pkg for the status struct.
module yiq2ycc_div
    import yiq2ycc_pkg::*;
#(
    parameter int NUM_W = 36,
    parameter int DEN_W = 18
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output div_stat_t        stat,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] work_reg, work_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_diff;
    logic             fits;

    assign trial      = {rem_reg, work_reg[NUM_W-1]};
    assign fits       = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit into the remainder, quotient bit into the LSB
            rem_next  = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            work_next = {work_reg[NUM_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = work_reg;

endmodule

@@ rtl/yiq_to_ycbcr_converter_top.sv @@
// YIQ to BT.601 YCbCr converter, four-stage pipeline, one item per clock while in_stall is low.
// An accepted item moves through stage registers A, B, C and D; out_valid is stage D's valid bit.
// Reset: registers return to their reset values, then the scale dividers run until
// both have finished; in_stall stays high meanwhile.
// Every register write reruns the same derivation, with in_stall high again.
// Depends on yiq2ycc_pkg and yiq2ycc_div.
module yiq_to_ycbcr_converter_top
    import yiq2ycc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [15:0]           luma_in,
    input  logic signed [15:0]    inphase_in,
    input  logic signed [15:0]    quadrature_in,
    input  logic                  line_end_in,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           luma_out,
    output logic [15:0]           blue_diff_out,
    output logic [15:0]           red_diff_out,
    output logic                  line_end_out
);

    localparam int LNUM_W = (COEF_FRAC_BITS + 20 > 33) ? COEF_FRAC_BITS + 20 : 33;
    localparam int LDEN_W = 18;
    localparam int CNUM_W = (COEF_FRAC_BITS + 17 > 33) ? COEF_FRAC_BITS + 17 : 33;
    localparam int CDEN_W = 16;
    localparam int CS     = COEF_FRAC_BITS + 8;

    localparam int PY_W   = 50;            // 17-bit diff times 33-bit scale
    localparam int PC_W   = 49;            // 16-bit chroma times 33-bit scale
    localparam int IU_W   = PC_W - 12;
    localparam int KP_W   = IU_W + K_W;
    localparam int YSUM_W = 51;
    localparam int CSUM_W = 64;

    localparam logic signed [YSUM_W-1:0] Y_OFF = YSUM_W'(LUMA_OFFSET) << COEF_FRAC_BITS;
    localparam logic signed [YSUM_W-1:0] Y_LO  = YSUM_W'(OUT_MIN) << COEF_FRAC_BITS;
    localparam logic signed [YSUM_W-1:0] Y_HI  = YSUM_W'(OUT_MAX) << COEF_FRAC_BITS;
    localparam logic signed [CSUM_W-1:0] C_OFF = CSUM_W'(CHROMA_OFFSET) << CS;
    localparam logic signed [CSUM_W-1:0] C_LO  = CSUM_W'(OUT_MIN) << CS;
    localparam logic signed [CSUM_W-1:0] C_HI  = CSUM_W'(OUT_MAX) << CS;

    // ---------------- configuration and scale derivation ----------------
    logic [15:0] black_level_reg;
    logic [15:0] white_level_reg;
    logic        white_pt_75_reg;
    logic [15:0] chroma_gain_reg;
    logic        recalc_req_reg;
    logic [31:0] luma_scale_reg;
    logic [31:0] chroma_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_level_reg <= BLACK_LEVEL_RST;
            white_level_reg <= WHITE_LEVEL_RST;
            white_pt_75_reg <= WHITE_PT_75_RST;
            chroma_gain_reg <= CHROMA_GAIN_RST;
            recalc_req_reg  <= 1'b1;
        end
        else
        begin
            recalc_req_reg <= cfg_wr_en;
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BLACK_LEVEL: black_level_reg <= cfg_data[15:0];
                    REG_WHITE_LEVEL: white_level_reg <= cfg_data[15:0];
                    REG_WHITE_PT_75: white_pt_75_reg <= cfg_data[0];
                    REG_CHROMA_GAIN: chroma_gain_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    logic [15:0]       span;
    logic              span_zero;
    logic [LNUM_W-1:0] luma_numer;
    logic [LDEN_W-1:0] luma_denom;
    logic [CNUM_W-1:0] chroma_numer;
    logic [LNUM_W-1:0] luma_quot;
    logic [CNUM_W-1:0] chroma_quot;
    logic [31:0]       luma_quot_sat;
    logic [31:0]       chroma_quot_sat;
    div_stat_t         luma_div_stat;
    div_stat_t         chroma_div_stat;
    logic              recalc_busy;

    assign span      = white_level_reg - black_level_reg;
    assign span_zero = white_level_reg <= black_level_reg;

    // round to nearest: add half the divisor before dividing
    assign luma_numer = (LNUM_W'(white_pt_75_reg ? LUMA_K_WP75 : LUMA_K_FULL) << COEF_FRAC_BITS)
                      + LNUM_W'({span, 1'b0});
    assign luma_denom   = {span, 2'b00};
    assign chroma_numer = (CNUM_W'(chroma_gain_reg) << COEF_FRAC_BITS) + CNUM_W'(span[15:1]);

    yiq2ycc_div #(
        .NUM_W (LNUM_W),
        .DEN_W (LDEN_W)
    ) u_luma_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (recalc_req_reg),
        .numer (luma_numer),
        .denom (luma_denom),
        .stat  (luma_div_stat),
        .quot  (luma_quot)
    );

    yiq2ycc_div #(
        .NUM_W (CNUM_W),
        .DEN_W (CDEN_W)
    ) u_chroma_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (recalc_req_reg),
        .numer (chroma_numer),
        .denom (span),
        .stat  (chroma_div_stat),
        .quot  (chroma_quot)
    );

    assign luma_quot_sat   = (|luma_quot[LNUM_W-1:32]) ? '1 : luma_quot[31:0];
    assign chroma_quot_sat = (|chroma_quot[CNUM_W-1:32]) ? '1 : chroma_quot[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_scale_reg   <= '0;
            chroma_scale_reg <= '0;
        end
        else
        begin
            if (luma_div_stat.done)
                luma_scale_reg <= span_zero ? '0 : luma_quot_sat;
            if (chroma_div_stat.done)
                chroma_scale_reg <= span_zero ? '0 : chroma_quot_sat;
        end
    end

    assign recalc_busy = recalc_req_reg | luma_div_stat.busy | luma_div_stat.done
                       | chroma_div_stat.busy | chroma_div_stat.done;

    // ---------------- pipeline control ----------------
    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic ready_a, ready_b, ready_c, ready_d;
    logic in_take;

    assign ready_d  = !vd_reg || !out_stall;
    assign ready_c  = !vc_reg || ready_d;
    assign ready_b  = !vb_reg || ready_c;
    assign ready_a  = !va_reg || ready_b;
    assign in_stall = recalc_busy || !ready_a;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                va_reg <= in_take;
            if (ready_b)
                vb_reg <= va_reg;
            if (ready_c)
                vc_reg <= vb_reg;
            if (ready_d)
                vd_reg <= vc_reg;
        end
    end

    // ---------------- stage A: scale multiplies ----------------
    logic signed [16:0]     y_diff;
    logic signed [32:0]     luma_scale_s;
    logic signed [32:0]     chroma_scale_s;
    logic signed [PY_W-1:0] a_luma_prod_reg;
    logic signed [PC_W-1:0] a_i_prod_reg;
    logic signed [PC_W-1:0] a_q_prod_reg;
    logic                   a_line_end_reg;

    assign y_diff         = $signed({1'b0, luma_in}) - $signed({1'b0, black_level_reg});
    assign luma_scale_s   = $signed({1'b0, luma_scale_reg});
    assign chroma_scale_s = $signed({1'b0, chroma_scale_reg});

    always_ff @(posedge clk)
    begin
        if (ready_a)
        begin
            a_luma_prod_reg <= PY_W'(y_diff) * PY_W'(luma_scale_s);
            a_i_prod_reg    <= PC_W'(inphase_in) * PC_W'(chroma_scale_s);
            a_q_prod_reg    <= PC_W'(quadrature_in) * PC_W'(chroma_scale_s);
            a_line_end_reg  <= line_end_in;
        end
    end

    // ---------------- stage B: rotation multiplies, luma offset ----------------
    logic signed [IU_W-1:0]   iu;
    logic signed [IU_W-1:0]   qu;
    logic signed [KP_W-1:0]   b_cb_i_reg;
    logic signed [KP_W-1:0]   b_cb_q_reg;
    logic signed [KP_W-1:0]   b_cr_i_reg;
    logic signed [KP_W-1:0]   b_cr_q_reg;
    logic signed [YSUM_W-1:0] b_ysum_reg;
    logic                     b_line_end_reg;

    // drop the 12 gain fraction bits, rounding toward minus infinity
    assign iu = $signed(a_i_prod_reg[PC_W-1:12]);
    assign qu = $signed(a_q_prod_reg[PC_W-1:12]);

    always_ff @(posedge clk)
    begin
        if (ready_b)
        begin
            b_cb_i_reg     <= KP_W'(iu) * KP_W'(K_CB_I);
            b_cb_q_reg     <= KP_W'(qu) * KP_W'(K_CB_Q);
            b_cr_i_reg     <= KP_W'(iu) * KP_W'(K_CR_I);
            b_cr_q_reg     <= KP_W'(qu) * KP_W'(K_CR_Q);
            b_ysum_reg     <= YSUM_W'(a_luma_prod_reg) + Y_OFF;
            b_line_end_reg <= a_line_end_reg;
        end
    end

    // ---------------- stage C: chroma sums ----------------
    logic signed [CSUM_W-1:0] c_cb_reg;
    logic signed [CSUM_W-1:0] c_cr_reg;
    logic signed [YSUM_W-1:0] c_ysum_reg;
    logic                     c_line_end_reg;

    always_ff @(posedge clk)
    begin
        if (ready_c)
        begin
            c_cb_reg       <= C_OFF - CSUM_W'(b_cb_i_reg) + CSUM_W'(b_cb_q_reg);
            c_cr_reg       <= C_OFF + CSUM_W'(b_cr_i_reg) + CSUM_W'(b_cr_q_reg);
            c_ysum_reg     <= b_ysum_reg;
            c_line_end_reg <= b_line_end_reg;
        end
    end

    // ---------------- stage D: clamp and floor ----------------
    function automatic logic [15:0] clamp_luma(input logic signed [YSUM_W-1:0] s);
        logic [15:0] r;
        if (s < Y_LO)
            r = OUT_MIN;
        else if (s > Y_HI)
            r = OUT_MAX;
        else
            r = s[COEF_FRAC_BITS +: 16];
        return r;
    endfunction

    function automatic logic [15:0] clamp_chroma(input logic signed [CSUM_W-1:0] s);
        logic [15:0] r;
        if (s < C_LO)
            r = OUT_MIN;
        else if (s > C_HI)
            r = OUT_MAX;
        else
            r = s[CS +: 16];
        return r;
    endfunction

    logic [15:0] d_luma_reg;
    logic [15:0] d_cb_reg;
    logic [15:0] d_cr_reg;
    logic        d_line_end_reg;

    always_ff @(posedge clk)
    begin
        if (ready_d)
        begin
            d_luma_reg     <= clamp_luma(c_ysum_reg);
            d_cb_reg       <= clamp_chroma(c_cb_reg);
            d_cr_reg       <= clamp_chroma(c_cr_reg);
            d_line_end_reg <= c_line_end_reg;
        end
    end

    assign out_valid     = vd_reg;
    assign luma_out      = d_luma_reg;
    assign blue_diff_out = d_cb_reg;
    assign red_diff_out  = d_cr_reg;
    assign line_end_out  = d_line_end_reg;

endmodule

@@ rtl/yiq2ycc_chk.sv @@
// Port-level checker for the YIQ to YCbCr converter, bound to the top level.
// Depends on yiq2ycc_pkg for the output range.
module yiq2ycc_chk
    import yiq2ycc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wr_en,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] luma_out,
    input logic [15:0] blue_diff_out,
    input logic [15:0] red_diff_out,
    input logic        line_end_out
);

    // hold a stalled item
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(luma_out) && $stable(blue_diff_out)
            && $stable(red_diff_out) && $stable(line_end_out))
        else $error("stalled output item changed");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> luma_out >= OUT_MIN && luma_out <= OUT_MAX
            && blue_diff_out >= OUT_MIN && blue_diff_out <= OUT_MAX
            && red_diff_out >= OUT_MIN && red_diff_out <= OUT_MAX)
        else $error("output sample outside clamp range");

    // a register write restarts scale derivation, so input must be held off
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> in_stall)
        else $error("input accepted while scales are being derived");

endmodule

bind yiq_to_ycbcr_converter_top yiq2ycc_chk u_yiq2ycc_chk (.*);

@@ verif/yiq2ycc_checker.sv @@
`timescale 1ns / 1ps
// Checker for the YIQ to YCbCr converter: follows register writes, predicts every
// converted pixel and compares it with the pixel that leaves the block.
// Depends on yiq2ycc_pkg.
module yiq2ycc_checker
    import yiq2ycc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [15:0]           luma_in,
    input  logic signed [15:0]    inphase_in,
    input  logic signed [15:0]    quadrature_in,
    input  logic                  line_end_in,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [15:0]           luma_out,
    input  logic [15:0]           blue_diff_out,
    input  logic [15:0]           red_diff_out,
    input  logic                  line_end_out,
    output int                    fail_count,
    output int                    pending
);

    localparam int FRAC        = 16;
    localparam int CHROMA_FRAC = FRAC + 8;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic [15:0] y;
        logic [15:0] cb;
        logic [15:0] cr;
        logic        eol;
    } ycc_pixel_t;

    logic [15:0] black_lvl;
    logic [15:0] white_lvl;
    logic        wp75;
    logic [15:0] gain_reg;
    logic [31:0] luma_gain;
    logic [31:0] chroma_gain_k;
    ycc_pixel_t  expected_pixels[$];

    // Luma gain carries FRAC fractional bits, chroma gain FRAC + 12.
    function automatic void refresh_scales();
        logic [63:0] span;
        logic [63:0] num;
        logic [63:0] quo;
        if (white_lvl <= black_lvl) begin
            luma_gain     = '0;
            chroma_gain_k = '0;
        end
        else begin
            span = 64'(white_lvl) - 64'(black_lvl);
            num  = (64'(LUMA_SPAN_CODE) * (wp75 ? 64'd5 : 64'd4)) << FRAC;
            quo  = (num + 2 * span) / (4 * span);
            luma_gain = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
            num  = 64'(gain_reg) << FRAC;
            quo  = (num + span / 2) / span;
            chroma_gain_k = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
        end
    endfunction

    // Clamp in the scaled domain, then floor to an output code.
    function automatic logic [15:0] clamp_code(input longint sum, input int frac);
        longint lo;
        longint hi;
        lo = longint'({48'd0, OUT_MIN}) <<< frac;
        hi = longint'({48'd0, OUT_MAX}) <<< frac;
        if (sum < lo)
            return OUT_MIN;
        if (sum > hi)
            return OUT_MAX;
        return 16'(sum >>> frac);
    endfunction

    function automatic ycc_pixel_t convert_pixel(input logic [15:0] y,
                                                 input logic signed [15:0] i_s,
                                                 input logic signed [15:0] q_s,
                                                 input logic eol);
        longint     diff;
        longint     ysum;
        longint     iu;
        longint     qu;
        longint     off;
        longint     cb;
        longint     cr;
        ycc_pixel_t px;
        diff = longint'({48'd0, y}) - longint'({48'd0, black_lvl});
        ysum = diff * longint'({32'd0, luma_gain}) + (longint'({48'd0, LUMA_OFFSET}) <<< FRAC);
        // arithmetic shift floors the scaled chroma to FRAC fractional bits
        iu   = (longint'(i_s) * longint'({32'd0, chroma_gain_k})) >>> 12;
        qu   = (longint'(q_s) * longint'({32'd0, chroma_gain_k})) >>> 12;
        off  = longint'({48'd0, CHROMA_OFFSET}) <<< CHROMA_FRAC;
        cb   = off - iu * longint'(K_CB_I) + qu * longint'(K_CB_Q);
        cr   = off + iu * longint'(K_CR_I) + qu * longint'(K_CR_Q);
        px.y   = clamp_code(ysum, FRAC);
        px.cb  = clamp_code(cb, CHROMA_FRAC);
        px.cr  = clamp_code(cr, CHROMA_FRAC);
        px.eol = eol;
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("checker: %s mismatch, got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ycc_pixel_t want;
        if (!rst_n)
        begin
            black_lvl = BLACK_LEVEL_RST;
            white_lvl = WHITE_LEVEL_RST;
            wp75      = WHITE_PT_75_RST;
            gain_reg  = CHROMA_GAIN_RST;
            refresh_scales();
            expected_pixels.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected item, luma", luma_out, 0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (luma_out !== want.y)
                        report_mismatch("luma", luma_out, want.y);
                    if (blue_diff_out !== want.cb)
                        report_mismatch("cb", blue_diff_out, want.cb);
                    if (red_diff_out !== want.cr)
                        report_mismatch("cr", red_diff_out, want.cr);
                    if (line_end_out !== want.eol)
                        report_mismatch("line end", line_end_out, want.eol);
                end
            end
            if (in_valid && !in_stall)
                expected_pixels.push_back(convert_pixel(luma_in, inphase_in, quadrature_in,
                                                        line_end_in));
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BLACK_LEVEL: black_lvl = cfg_data[15:0];
                    REG_WHITE_LEVEL: white_lvl = cfg_data[15:0];
                    REG_WHITE_PT_75: wp75      = cfg_data[0];
                    REG_CHROMA_GAIN: gain_reg  = cfg_data[15:0];
                    default: ;
                endcase
                refresh_scales();
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the YIQ to YCbCr converter: clock, reset, register setup,
// pixel stimulus and output stalls; checking lives in yiq2ycc_checker.
// Depends on yiq2ycc_pkg, yiq_to_ycbcr_converter_top and yiq2ycc_checker.
module tb;
    import yiq2ycc_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_LEN    = 300;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [15:0]           luma_in;
    logic signed [15:0]    inphase_in;
    logic signed [15:0]    quadrature_in;
    logic                  line_end_in;
    logic                  out_valid;
    logic                  out_stall;
    logic [15:0]           luma_out;
    logic [15:0]           blue_diff_out;
    logic [15:0]           red_diff_out;
    logic                  line_end_out;

    int          fail_count;
    int          pending;
    int          cycle_cnt     = 0;
    int          tx_max_gap    = 0;
    int          rx_max_gap    = 0;
    int          rx_wait       = 0;
    int          results_taken = 0;
    logic [15:0] cur_black     = BLACK_LEVEL_RST;
    logic [15:0] cur_white     = WHITE_LEVEL_RST;

    always #2 clk = ~clk;

    yiq_to_ycbcr_converter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .luma_in       (luma_in),
        .inphase_in    (inphase_in),
        .quadrature_in (quadrature_in),
        .line_end_in   (line_end_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .luma_out      (luma_out),
        .blue_diff_out (blue_diff_out),
        .red_diff_out  (red_diff_out),
        .line_end_out  (line_end_out)
    );

    yiq2ycc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .luma_in       (luma_in),
        .inphase_in    (inphase_in),
        .quadrature_in (quadrature_in),
        .line_end_in   (line_end_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .luma_out      (luma_out),
        .blue_diff_out (blue_diff_out),
        .red_diff_out  (red_diff_out),
        .line_end_out  (line_end_out),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Receiver: stall a random number of cycles after each item, and hold off
    // once for a long stretch so the pipeline fills and backs up.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_taken++;
                rx_wait = (results_taken == HOLD_AT) ? HOLD_LEN
                                                     : $urandom_range(rx_max_gap, 0);
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Offer one item, hold it until taken, then idle for a random gap.
    task automatic send_pixel(input logic [15:0] y, input logic [15:0] i_val,
                              input logic [15:0] q_val, input logic eol);
        int gap;
        in_valid      <= 1'b1;
        luma_in       <= y;
        inphase_in    <= i_val;
        quadrature_in <= q_val;
        line_end_in   <= eol;
        do
            @(posedge clk);
        while (in_stall);
        gap = $urandom_range(tx_max_gap, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted pixel has come out.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_levels(input logic [15:0] blk, input logic [15:0] wht,
                              input logic [15:0] wpt, input logic [15:0] gain);
        settle();
        put_reg(REG_BLACK_LEVEL, blk);
        put_reg(REG_WHITE_LEVEL, wht);
        put_reg(REG_WHITE_PT_75, wpt);
        put_reg(REG_CHROMA_GAIN, gain);
        cfg_wr_en <= 1'b0;
        cur_black = blk;
        cur_white = wht;
    endtask

    task automatic run_phase(input int tx_gap, input int rx_gap, input int count);
        logic [15:0] y;
        logic [15:0] ii;
        logic [15:0] qq;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] luma_pick[4];
        logic [15:0] chroma_pick[4];
        tx_max_gap = tx_gap;
        rx_max_gap <= rx_gap;
        lo = (cur_black < cur_white) ? cur_black : cur_white;
        hi = (cur_black < cur_white) ? cur_white : cur_black;
        luma_pick   = '{16'h0000, 16'hFFFF, cur_black, cur_white};
        chroma_pick = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        repeat (count)
        begin
            case ($urandom_range(3, 0))
                0:
                begin
                    // in-range luma and moderate chroma, so most outputs avoid the clamp
                    y  = 16'($urandom_range(hi, lo));
                    ii = 16'($urandom_range(4095, 0)) - 16'd2048;
                    qq = 16'($urandom_range(4095, 0)) - 16'd2048;
                end
                1:
                begin
                    y  = luma_pick[$urandom_range(3, 0)];
                    ii = chroma_pick[$urandom_range(3, 0)];
                    qq = chroma_pick[$urandom_range(3, 0)];
                end
                default:
                begin
                    y  = 16'($urandom);
                    ii = 16'($urandom);
                    qq = 16'($urandom);
                end
            endcase
            send_pixel(y, ii, qq, $urandom_range(7, 0) == 0);
        end
    endtask

    initial
    begin
        logic [15:0] lo;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_BLACK_LEVEL;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        luma_in       <= '0;
        inphase_in    <= '0;
        quadrature_in <= '0;
        line_end_in   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners under the reset registers
        tx_max_gap = 19;
        rx_max_gap <= 19;
        send_pixel(16'd0,     16'h0000, 16'h0000, 1'b0);
        send_pixel(16'd65535, 16'h7FFF, 16'h7FFF, 1'b1);
        send_pixel(16'd0,     16'h8000, 16'h8000, 1'b0);
        send_pixel(16'd16384, 16'h0000, 16'h0000, 1'b0);
        send_pixel(16'd54016, 16'h0000, 16'h0000, 1'b1);
        send_pixel(16'd16383, 16'h0000, 16'h0000, 1'b0);
        send_pixel(16'd54017, 16'h0000, 16'h0000, 1'b0);
        send_pixel(16'd32768, 16'h7FFF, 16'h8000, 1'b0);
        send_pixel(16'd32768, 16'h8000, 16'h7FFF, 1'b1);
        send_pixel(16'd32768, 16'h0001, 16'hFFFF, 1'b0);
        send_pixel(16'd32768, 16'hFFFF, 16'h0001, 1'b0);
        send_pixel(16'd35200, 16'h7FFF, 16'h0000, 1'b0);
        send_pixel(16'd35200, 16'h0000, 16'h8000, 1'b1);
        send_pixel(16'd35200, 16'h8000, 16'h0000, 1'b0);
        send_pixel(16'd35200, 16'h0000, 16'h7FFF, 1'b0);
        send_pixel(16'hAAAA,  16'h5555, 16'hAAAA, 1'b1);

        // Back to back on both sides; the long receiver hold-off lands here
        run_phase(0, 0, 150);
        // Widest span, 75 percent white point, top chroma gain
        set_levels(16'd0, 16'hFFFF, 16'd1, 16'hFFFF);
        run_phase(19, 19, 130);
        // White below black: scales drop to zero
        set_levels(16'hFFFF, 16'd0, 16'd0, 16'h1234);
        run_phase(5, 19, 110);
        // Span of one: luma gain saturates; only bit 0 of the white-point write counts
        set_levels(16'd1000, 16'd1001, 16'hFFFF, 16'hFFFF);
        run_phase(19, 0, 120);
        // White equal to black, zero chroma gain, high bits set on the white-point write
        set_levels(16'd30000, 16'd30000, 16'hFFFE, 16'd0);
        run_phase(0, 19, 110);
        set_levels(BLACK_LEVEL_RST, WHITE_LEVEL_RST, 16'd1, CHROMA_GAIN_RST);
        run_phase(19, 5, 130);
        lo = 16'($urandom_range(40000, 0));
        set_levels(lo, lo + 16'($urandom_range(20000, 1)), 16'($urandom), 16'($urandom));
        run_phase(10, 10, 130);
        set_levels(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_phase(19, 19, 110);
        lo = 16'($urandom_range(2000, 0));
        set_levels(lo, lo + 16'($urandom_range(300, 1)), 16'd0, 16'($urandom_range(512, 0)));
        run_phase(0, 0, 130);

        settle();
        repeat (12) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
